>>> design/bmhq_pkg.sv
// bmhq_pkg: shared types, codes and the microcode rom of the max-heap queue
// used by bmhq_seq and binary_max_heap_queue_unit; no dependencies
`timescale 1ns / 1ps

package bmhq_pkg;

	localparam int KEY_W    = 32;
	localparam int TOTAL_W  = 11;
	localparam int STATUS_W = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// microprogram addresses
	typedef logic [3:0] uaddr_t;
	localparam uaddr_t UA_IDLE    = 4'd0;
	localparam uaddr_t UA_UP_TEST = 4'd1;
	localparam uaddr_t UA_UP_CMP  = 4'd2;
	localparam uaddr_t UA_PLACE   = 4'd3;
	localparam uaddr_t UA_DN_LAST = 4'd4;
	localparam uaddr_t UA_DN_LOAD = 4'd5;
	localparam uaddr_t UA_DN_TEST = 4'd6;
	localparam uaddr_t UA_DN_RC   = 4'd7;
	localparam uaddr_t UA_DN_CMP  = 4'd8;
	localparam uaddr_t UA_DONE    = 4'd9;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_PARENT,
		RD_LAST,
		RD_LCHILD,
		RD_RCHILD
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_KEY,
		WR_RDATA,
		WR_BEST
	} wr_sel_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_ZERO,
		POS_PARENT,
		POS_BEST
	} pos_sel_t;

	typedef enum logic [3:0] {
		JC_ALWAYS,
		JC_DISPATCH,
		JC_POS_ZERO,
		JC_KEY_GT_RD,
		JC_CNT_ZERO,
		JC_NO_LCHILD,
		JC_CHILD_GT_KEY,
		JC_OUT_FREE
	} cond_t;

	// writes, position moves and output loads only happen when the jump is taken
	typedef struct packed {
		logic     accept;
		rd_sel_t  rd;
		wr_sel_t  wr;
		pos_sel_t pos;
		logic     ld_key;
		logic     ld_child;
		logic     ld_out;
		cond_t    cond;
		uaddr_t   jump_a;
		uaddr_t   next_a;
	} uword_t;

	typedef struct packed {
		logic in_xfer;
		logic op_remove;
		logic heap_full;
		logic heap_empty;
		logic pos_zero;
		logic key_gt_rd;
		logic cnt_zero;
		logic no_lchild;
		logic child_gt_key;
		logic out_free;
	} seq_flags_t;

	function automatic logic key_gt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		return $signed(a) > $signed(b);
	endfunction

	function automatic uword_t ucode_rom(input uaddr_t a);
		uword_t w;
		w = '{accept: 1'b0, rd: RD_NONE, wr: WR_NONE, pos: POS_HOLD, ld_key: 1'b0,
			ld_child: 1'b0, ld_out: 1'b0, cond: JC_ALWAYS, jump_a: UA_IDLE,
			next_a: UA_IDLE};
		unique case (a)
			UA_IDLE: begin
				w.accept = 1'b1;
				w.cond   = JC_DISPATCH;
			end
			UA_UP_TEST: begin
				w.rd     = RD_PARENT;
				w.cond   = JC_POS_ZERO;
				w.jump_a = UA_PLACE;
				w.next_a = UA_UP_CMP;
			end
			UA_UP_CMP: begin
				// parent moves down into the hole
				w.wr     = WR_RDATA;
				w.pos    = POS_PARENT;
				w.cond   = JC_KEY_GT_RD;
				w.jump_a = UA_UP_TEST;
				w.next_a = UA_PLACE;
			end
			UA_PLACE: begin
				w.wr     = WR_KEY;
				w.jump_a = UA_DONE;
			end
			UA_DN_LAST: begin
				w.rd     = RD_LAST;
				w.cond   = JC_CNT_ZERO;
				w.jump_a = UA_DONE;
				w.next_a = UA_DN_LOAD;
			end
			UA_DN_LOAD: begin
				w.ld_key = 1'b1;
				w.pos    = POS_ZERO;
				w.jump_a = UA_DN_TEST;
			end
			UA_DN_TEST: begin
				w.rd     = RD_LCHILD;
				w.cond   = JC_NO_LCHILD;
				w.jump_a = UA_PLACE;
				w.next_a = UA_DN_RC;
			end
			UA_DN_RC: begin
				w.rd       = RD_RCHILD;
				w.ld_child = 1'b1;
				w.jump_a   = UA_DN_CMP;
			end
			UA_DN_CMP: begin
				// larger child moves up into the hole
				w.wr     = WR_BEST;
				w.pos    = POS_BEST;
				w.cond   = JC_CHILD_GT_KEY;
				w.jump_a = UA_DN_TEST;
				w.next_a = UA_PLACE;
			end
			UA_DONE: begin
				w.ld_out = 1'b1;
				w.cond   = JC_OUT_FREE;
				w.jump_a = UA_IDLE;
				w.next_a = UA_DONE;
			end
			default: ;
		endcase
		return w;
	endfunction

endpackage

>>> design/bmhq_seq.sv
// bmhq_seq: microprogram counter, control rom lookup and jump logic
// depends on bmhq_pkg
`timescale 1ns / 1ps

module bmhq_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  bmhq_pkg::seq_flags_t flags,
	output bmhq_pkg::uword_t     uw,
	output logic                taken
);

	bmhq_pkg::uaddr_t upc_q;
	bmhq_pkg::uaddr_t disp_a;
	bmhq_pkg::uaddr_t upc_d;

	assign uw = bmhq_pkg::ucode_rom(upc_q);

	always_comb begin
		unique case (uw.cond)
			bmhq_pkg::JC_ALWAYS:       taken = 1'b1;
			bmhq_pkg::JC_DISPATCH:     taken = flags.in_xfer;
			bmhq_pkg::JC_POS_ZERO:     taken = flags.pos_zero;
			bmhq_pkg::JC_KEY_GT_RD:    taken = flags.key_gt_rd;
			bmhq_pkg::JC_CNT_ZERO:     taken = flags.cnt_zero;
			bmhq_pkg::JC_NO_LCHILD:    taken = flags.no_lchild;
			bmhq_pkg::JC_CHILD_GT_KEY: taken = flags.child_gt_key;
			bmhq_pkg::JC_OUT_FREE:     taken = flags.out_free;
			default:                   taken = 1'b0;
		endcase
	end

	// refused operations go straight to the result step
	always_comb begin
		if (flags.op_remove) begin
			disp_a = flags.heap_empty ? bmhq_pkg::UA_DONE : bmhq_pkg::UA_DN_LAST;
		end else begin
			disp_a = flags.heap_full ? bmhq_pkg::UA_DONE : bmhq_pkg::UA_UP_TEST;
		end
	end

	always_comb begin
		if (!taken) begin
			upc_d = uw.next_a;
		end else if (uw.cond == bmhq_pkg::JC_DISPATCH) begin
			upc_d = disp_a;
		end else begin
			upc_d = uw.jump_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= bmhq_pkg::UA_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

>>> design/binary_max_heap_queue_unit.sv
// binary_max_heap_queue_unit: max-heap priority queue, heap memory and datapath
// depends on bmhq_pkg and bmhq_seq
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid / in_stall, opcode, key): opcode 0 inserts key, opcode 1
// removes the maximum. Output channel (out_valid / out_stall) returns one result per
// item: removed_value, top_value, entry_total and status (done, full, empty).
// One item is worked at a time; in_stall is low only while the sequencer waits at
// its idle step, which it reaches again as soon as the result sits in the output
// register, so the next item is taken while the previous result is still waiting.
// A refused item goes straight to the result step; an insert climbs toward the root
// and a removal sinks from the root to a slot without children or until a compare
// stops it. Each level reads the heap memory, compares and writes: an insert reads
// the parent, a removal reads the left and the right child slot.
// When the receiver stalls, the finished result holds in the output register and
// the following item waits at its last step until that register is free.
// Reset empties the heap (count to zero, no memory sweep) and drops any result.

module binary_max_heap_queue_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic signed [bmhq_pkg::KEY_W-1:0]    key,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [bmhq_pkg::KEY_W-1:0]    removed_value,
	output logic signed [bmhq_pkg::KEY_W-1:0]    top_value,
	output logic        [bmhq_pkg::TOTAL_W-1:0]  entry_total,
	output logic        [bmhq_pkg::STATUS_W-1:0] status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;
	localparam int KW = bmhq_pkg::KEY_W;

	bmhq_pkg::uword_t     uw;
	bmhq_pkg::seq_flags_t flags;
	logic                 taken;

	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	logic [KW-1:0] key_q;
	logic [KW-1:0] child_q;
	logic [KW-1:0] rdata_q;
	logic [KW-1:0] top_q;
	logic [KW-1:0] res_removed_q;
	logic [bmhq_pkg::STATUS_W-1:0] res_status_q;

	logic                          out_valid_q;
	logic [KW-1:0]                 out_removed_q;
	logic [KW-1:0]                 out_top_q;
	logic [bmhq_pkg::TOTAL_W-1:0]  out_total_q;
	logic [bmhq_pkg::STATUS_W-1:0] out_status_q;

	logic [KW-1:0] heap_mem [CAPACITY];

	logic          in_xfer;
	logic          heap_full;
	logic          heap_empty;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] lc_x;
	logic [XW-1:0] rc_x;
	logic [XW-1:0] count_x;
	logic [AW-1:0] parent_a;
	logic [AW-1:0] lc_a;
	logic [AW-1:0] rc_a;
	logic          rc_ok;
	logic          best_is_rc;
	logic [KW-1:0] best_val;
	logic [AW-1:0] best_a;
	logic          rd_en;
	logic [AW-1:0] rd_a;
	logic          wr_en;
	logic [KW-1:0] wdata;
	logic          out_ld;

	bmhq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw),
		.taken  (taken)
	);

	assign in_stall   = !uw.accept;
	assign in_xfer    = in_valid && uw.accept;
	assign heap_full  = (count_q == CW'(CAPACITY));
	assign heap_empty = (count_q == '0);

	// heap index arithmetic, widened so 2*i+2 never wraps
	assign pos_x    = XW'(pos_q);
	assign lc_x     = {1'b0, pos_q, 1'b1};
	assign rc_x     = lc_x + XW'(1);
	assign count_x  = XW'(count_q);
	assign parent_a = AW'((pos_q - AW'(1)) >> 1);
	assign lc_a     = lc_x[AW-1:0];
	assign rc_a     = rc_x[AW-1:0];
	assign rc_ok    = (rc_x < count_x);

	// left child wins a tie
	assign best_is_rc = rc_ok && bmhq_pkg::key_gt(rdata_q, child_q);
	assign best_val   = best_is_rc ? rdata_q : child_q;
	assign best_a     = best_is_rc ? rc_a : lc_a;

	always_comb begin
		flags              = '0;
		flags.in_xfer      = in_xfer;
		flags.op_remove    = (opcode == bmhq_pkg::OP_REMOVE);
		flags.heap_full    = heap_full;
		flags.heap_empty   = heap_empty;
		flags.pos_zero     = (pos_q == '0);
		flags.key_gt_rd    = bmhq_pkg::key_gt(key_q, rdata_q);
		flags.cnt_zero     = heap_empty;
		flags.no_lchild    = (lc_x >= count_x);
		flags.child_gt_key = bmhq_pkg::key_gt(best_val, key_q);
		flags.out_free     = !out_valid_q || !out_stall;
	end

	always_comb begin
		rd_en = 1'b1;
		unique case (uw.rd)
			bmhq_pkg::RD_PARENT: rd_a = parent_a;
			bmhq_pkg::RD_LAST:   rd_a = AW'(count_q);
			bmhq_pkg::RD_LCHILD: rd_a = lc_a;
			bmhq_pkg::RD_RCHILD: rd_a = rc_a;
			default: begin
				rd_en = 1'b0;
				rd_a  = '0;
			end
		endcase
	end

	always_comb begin
		wr_en = taken;
		unique case (uw.wr)
			bmhq_pkg::WR_KEY:   wdata = key_q;
			bmhq_pkg::WR_RDATA: wdata = rdata_q;
			bmhq_pkg::WR_BEST:  wdata = best_val;
			default: begin
				wr_en = 1'b0;
				wdata = key_q;
			end
		endcase
	end

	assign out_ld = taken && uw.ld_out;

	// heap memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[pos_q] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= heap_mem[rd_a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (opcode == bmhq_pkg::OP_INSERT) begin
					if (!heap_full) begin
						count_q <= count_q + CW'(1);
					end
				end else if (!heap_empty) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q         <= key;
			pos_q         <= AW'(count_q);
			res_removed_q <= '0;
			res_status_q  <= bmhq_pkg::ST_DONE;
			if (opcode == bmhq_pkg::OP_INSERT) begin
				if (heap_full) begin
					res_status_q <= bmhq_pkg::ST_FULL;
				end
			end else if (heap_empty) begin
				res_status_q <= bmhq_pkg::ST_EMPTY;
			end else begin
				res_removed_q <= top_q;
			end
		end else begin
			if (uw.ld_key) begin
				key_q <= rdata_q;
			end
			if (taken) begin
				case (uw.pos)
					bmhq_pkg::POS_ZERO:   pos_q <= '0;
					bmhq_pkg::POS_PARENT: pos_q <= parent_a;
					bmhq_pkg::POS_BEST:   pos_q <= best_a;
					default:              pos_q <= pos_q;
				endcase
			end
		end
		if (uw.ld_child) begin
			child_q <= rdata_q;
		end
		// shadow copy of the root
		if (wr_en && pos_q == '0) begin
			top_q <= wdata;
		end
		if (out_ld) begin
			out_removed_q <= res_removed_q;
			out_top_q     <= heap_empty ? '0 : top_q;
			out_total_q   <= bmhq_pkg::TOTAL_W'(count_q);
			out_status_q  <= res_status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = out_removed_q;
	assign top_value     = out_top_q;
	assign entry_total   = out_total_q;
	assign status        = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> pos_x < count_x)
		else $error("heap write outside occupied slots");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("sequencer still idle after input transfer");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == bmhq_pkg::ST_EMPTY |->
			out_removed_q == '0 && out_top_q == '0 && out_total_q == '0)
		else $error("refused removal reports nonzero fields");

endmodule
